// ----- hdl/ddo_pkg.sv -----
`default_nettype none

package ddo_pkg;

    // Iterative units
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_IDX_W = 5;
    localparam logic [CORDIC_IDX_W-1:0] CORDIC_LAST = CORDIC_IDX_W'(CORDIC_STEPS - 1);
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam int DIV_W     = 64;
    localparam int DEN_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    // Configuration
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_METER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_WIDTH     = 1'd1;
    localparam logic [15:0] TPM_RESET = 16'd400;
    localparam logic [23:0] TW_RESET  = 24'd57581;

    // Scale constants
    localparam logic [29:0] BAM_SCALE = 30'd683565276;
    localparam logic [19:0] US_PER_S  = 20'd1000000;
    localparam logic [43:0] TH_CLAMP  = 44'h800_0000_0000;

    // Datapath operations issued by the controller
    typedef logic [4:0] t_op;
    localparam t_op OP_NOP     = 5'd0;
    localparam t_op OP_LOAD    = 5'd1;
    localparam t_op OP_DIV_D   = 5'd2;
    localparam t_op OP_CAP_D   = 5'd3;
    localparam t_op OP_DIV_M   = 5'd4;
    localparam t_op OP_CAP_M   = 5'd5;
    localparam t_op OP_DIV_T   = 5'd6;
    localparam t_op OP_CAP_T   = 5'd7;
    localparam t_op OP_BAM_LO  = 5'd8;
    localparam t_op OP_BAM_HI  = 5'd9;
    localparam t_op OP_COR_H   = 5'd10;
    localparam t_op OP_CAP_H   = 5'd11;
    localparam t_op OP_MUL_LO  = 5'd12;
    localparam t_op OP_MUL_HI  = 5'd13;
    localparam t_op OP_UPDATE  = 5'd14;
    localparam t_op OP_COR_Q   = 5'd15;
    localparam t_op OP_CAP_Q   = 5'd16;
    localparam t_op OP_MUL_LIN = 5'd17;
    localparam t_op OP_DIV_LIN = 5'd18;
    localparam t_op OP_CAP_LIN = 5'd19;
    localparam t_op OP_MUL_ANG = 5'd20;
    localparam t_op OP_DIV_ANG = 5'd21;
    localparam t_op OP_CAP_ANG = 5'd22;
    localparam t_op OP_OUT     = 5'd23;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic cor_busy;
        logic cor_done;
    } t_status;

    // Arctangent of 2^-i in binary-angle units.
    function automatic logic [31:0] atan_lut(input logic [CORDIC_IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Signed saturation of a sign and magnitude quotient to 32 bits.
    function automatic logic [31:0] sat32(input logic neg, input logic [DIV_W-1:0] mag);
        logic [31:0] v;
        if (neg) begin
            if (mag > DIV_W'(64'h8000_0000)) begin
                v = 32'h8000_0000;
            end else begin
                v = 32'(-mag[31:0]);
            end
        end else begin
            if (mag > DIV_W'(64'h7FFF_FFFF)) begin
                v = 32'h7FFF_FFFF;
            end else begin
                v = mag[31:0];
            end
        end
        return v;
    endfunction

    // Round Q2.30 to Q1.15 with saturation.
    function automatic logic [15:0] to_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0]    t;
        logic signed [CORDIC_W-15:0] r;
        logic [15:0]                 q;
        t = (CORDIC_W+1)'(v) + (CORDIC_W+1)'(16384);
        r = (CORDIC_W-14)'(t >>> 15);
        if (r > (CORDIC_W-14)'(32767)) begin
            q = 16'h7FFF;
        end else if (r < -(CORDIC_W-14)'(32768)) begin
            q = 16'h8000;
        end else begin
            q = r[15:0];
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/differential_drive_odometry.sv -----
// Requests: a new request is taken only once the previous one has been through its
// sequence of five divisions on the single bit-serial divider and two CORDIC runs.
// Reset: synchronous, active low; pose and previous counts clear to zero and the
// configuration returns to 400 ticks per meter and a 57581 track width.
`default_nettype none

// Differential-drive wheel odometry.
//
// A request carries absolute left and right encoder counts and the elapsed time.
// The controller (ddo_ctrl) steps the datapath (ddo_datapath) through the update:
//   - travel d and differential travel dm by division by the tick scale,
//   - heading change th = dm / track width, converted to binary-angle units,
//   - cos and sin of the old heading by CORDIC, then the position moves by d
//     along that heading and the heading advances,
//   - the half-heading quaternion by a second CORDIC run,
//   - linear and angular velocity by division by the elapsed time, forced to
//     zero when the elapsed time is zero.
// The result sits in an output register; a new request is taken while it waits,
// and the sequence stalls before its final load until the old result has left.
module differential_drive_odometry (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ddo_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ddo_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic signed [31:0]              i_left_count,
    input  wire logic signed [31:0]              i_right_count,
    input  wire logic [23:0]                     i_elapsed_us,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic signed [31:0]                   o_pos_x,
    output logic signed [31:0]                   o_pos_y,
    output logic [31:0]                          o_heading,
    output logic signed [15:0]                   o_quat_z,
    output logic signed [15:0]                   o_quat_w,
    output logic signed [31:0]                   o_linear_velocity,
    output logic signed [31:0]                   o_angular_velocity
);

    ddo_pkg::t_cmd    cmd;
    ddo_pkg::t_status status;

    ddo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ddo_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_left_count       (i_left_count),
        .i_right_count      (i_right_count),
        .i_elapsed_us       (i_elapsed_us),
        .o_pos_x            (o_pos_x),
        .o_pos_y            (o_pos_y),
        .o_heading          (o_heading),
        .o_quat_z           (o_quat_z),
        .o_quat_w           (o_quat_w),
        .o_linear_velocity  (o_linear_velocity),
        .o_angular_velocity (o_angular_velocity)
    );

`ifndef SYNTHESIS
    // The iterative units are never left running when a new request may enter.
    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!status.div_busy && !status.cor_busy))
        else $error("iterative unit busy while idle");

    // Taking a request starts the sequence at once.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("controller stayed idle after a request");

    // The divider and the CORDIC are never active together.
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(status.div_busy && status.cor_busy))
        else $error("divider and CORDIC overlap");
`endif

endmodule

`default_nettype wire

// ----- hdl/ddo_divider.sv -----
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module ddo_divider (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ddo_pkg::DIV_W-1:0]  i_num,
    input  wire logic [ddo_pkg::DEN_W-1:0]  i_den,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [ddo_pkg::DIV_W-1:0]       o_quot
);

    logic [ddo_pkg::DIV_W-1:0]     r_q;
    logic [ddo_pkg::DEN_W:0]       r_rem;
    logic [ddo_pkg::DEN_W-1:0]     r_den;
    logic [ddo_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [ddo_pkg::DEN_W:0] rem_sh;
    logic                    fits;
    logic [ddo_pkg::DEN_W:0] rem_nx;

    always_comb begin
        rem_sh = {r_rem[ddo_pkg::DEN_W-1:0], r_q[ddo_pkg::DIV_W-1]};
        fits   = rem_sh >= {1'b0, r_den};
        rem_nx = fits ? rem_sh - {1'b0, r_den} : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ddo_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[ddo_pkg::DIV_W-2:0], fits};
            r_rem <= rem_nx;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ----- hdl/ddo_cordic.sv -----
`default_nettype none

// Rotation-mode CORDIC, one micro-rotation per cycle, results in Q2.30.
module ddo_cordic (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [31:0]                         i_angle,
    output logic                                     o_busy,
    output logic                                     o_done,
    output logic signed [ddo_pkg::CORDIC_W-1:0]      o_cos,
    output logic signed [ddo_pkg::CORDIC_W-1:0]      o_sin
);

    logic signed [ddo_pkg::CORDIC_W-1:0] r_x;
    logic signed [ddo_pkg::CORDIC_W-1:0] r_y;
    logic signed [ddo_pkg::CORDIC_W-1:0] r_z;
    logic [ddo_pkg::CORDIC_IDX_W-1:0]    r_i;
    logic                                r_flip;
    logic                                r_busy;
    logic                                r_done;

    logic                                flip;
    logic [31:0]                         a_rot;
    logic signed [ddo_pkg::CORDIC_W-1:0] x_sh;
    logic signed [ddo_pkg::CORDIC_W-1:0] y_sh;
    logic signed [ddo_pkg::CORDIC_W-1:0] atan_v;

    always_comb begin
        // Second and third quadrant angles are turned by a half turn.
        flip   = i_angle[31] ^ i_angle[30];
        a_rot  = {i_angle[31] ^ flip, i_angle[30:0]};
        x_sh   = r_x >>> r_i;
        y_sh   = r_y >>> r_i;
        atan_v = $signed({2'b00, ddo_pkg::atan_lut(r_i)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == ddo_pkg::CORDIC_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= flip;
            r_x    <= ddo_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= ddo_pkg::CORDIC_W'($signed(a_rot));
        end else if (r_busy) begin
            if (!r_z[ddo_pkg::CORDIC_W-1]) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_v;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

`default_nettype wire

// ----- hdl/ddo_datapath.sv -----
`default_nettype none

// Odometry datapath: pose state, configuration, multipliers, divider, CORDIC.
module ddo_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire ddo_pkg::t_cmd                     i_cmd,
    output ddo_pkg::t_status                       o_status,
    input  wire logic                              i_cfg_we,
    input  wire logic [ddo_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ddo_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic signed [31:0]                i_left_count,
    input  wire logic signed [31:0]                i_right_count,
    input  wire logic [23:0]                       i_elapsed_us,
    output logic signed [31:0]                     o_pos_x,
    output logic signed [31:0]                     o_pos_y,
    output logic [31:0]                            o_heading,
    output logic signed [15:0]                     o_quat_z,
    output logic signed [15:0]                     o_quat_w,
    output logic signed [31:0]                     o_linear_velocity,
    output logic signed [31:0]                     o_angular_velocity
);

    localparam int CW = ddo_pkg::CORDIC_W;

    // Configuration and pose state
    logic [15:0]        r_tpm;
    logic [23:0]        r_tw;
    logic signed [31:0] r_prev_l;
    logic signed [31:0] r_prev_r;
    logic [31:0]        r_pos_x;
    logic [31:0]        r_pos_y;
    logic [31:0]        r_head;

    // Working registers
    logic signed [31:0]           r_lc;
    logic signed [31:0]           r_rc;
    logic [23:0]                  r_el;
    logic signed [33:0]           r_sum;
    logic signed [33:0]           r_diff;
    logic                         r_neg;
    logic signed [31:0]           r_d;
    logic signed [31:0]           r_dm;
    logic [47:0]                  r_thm;
    logic [47:0]                  r_th48;
    logic                         r_thneg;
    logic [47:0]                  r_bam_lo;
    logic [31:0]                  r_dbam;
    logic signed [CW-1:0]         r_cos;
    logic signed [CW-1:0]         r_sin;
    logic signed [63:0]           r_px;
    logic signed [63:0]           r_py;
    logic [ddo_pkg::DIV_W-1:0]    r_prod;
    logic [15:0]                  r_qz;
    logic [15:0]                  r_qw;
    logic [31:0]                  r_lin;
    logic [31:0]                  r_ang;

    // Output registers
    logic [31:0] r_o_x;
    logic [31:0] r_o_y;
    logic [31:0] r_o_head;
    logic [15:0] r_o_qz;
    logic [15:0] r_o_qw;
    logic [31:0] r_o_lin;
    logic [31:0] r_o_ang;

    logic [15:0]               tpm_eff;
    logic [23:0]               tw_eff;
    logic [33:0]               sum_mag;
    logic [33:0]               diff_mag;
    logic [31:0]               dm_mag;
    logic [31:0]               d_mag;
    logic [43:0]               thc;
    logic                      div_start;
    logic [ddo_pkg::DIV_W-1:0] div_num;
    logic [ddo_pkg::DEN_W-1:0] div_den;
    logic                      div_neg;
    logic                      div_busy;
    logic                      div_done;
    logic [ddo_pkg::DIV_W-1:0] div_quot;
    logic                      cor_start;
    logic [31:0]               cor_angle;
    logic                      cor_busy;
    logic                      cor_done;
    logic signed [CW-1:0]      cor_cos;
    logic signed [CW-1:0]      cor_sin;
    logic [61:0]               bam_p;
    logic [15:0]               bam_hi;
    logic [47:0]               bam_sum;
    logic [51:0]               lin_p;
    logic [63:0]               ang_p;
    logic [31:0]               sat_q;

    always_comb begin
        // A zero register acts as one.
        tpm_eff  = (r_tpm == 16'd0) ? 16'd1 : r_tpm;
        tw_eff   = (r_tw == 24'd0) ? 24'd1 : r_tw;
        sum_mag  = r_sum[33] ? 34'(-r_sum) : 34'(r_sum);
        diff_mag = r_diff[33] ? 34'(-r_diff) : 34'(r_diff);
        dm_mag   = r_dm[31] ? 32'(-r_dm) : 32'(r_dm);
        d_mag    = r_d[31] ? 32'(-r_d) : 32'(r_d);
        thc      = (r_thm > 48'(ddo_pkg::TH_CLAMP)) ? ddo_pkg::TH_CLAMP : r_thm[43:0];
        bam_p    = {30'd0, r_th48[31:0]} * {32'd0, ddo_pkg::BAM_SCALE};
        bam_hi   = r_th48[47:32] * ddo_pkg::BAM_SCALE[15:0];
        bam_sum  = r_bam_lo + {bam_hi, 32'd0};
        lin_p    = {20'd0, d_mag} * {32'd0, ddo_pkg::US_PER_S};
        ang_p    = {20'd0, thc} * {44'd0, ddo_pkg::US_PER_S};
        sat_q    = ddo_pkg::sat32(r_neg, div_quot);
    end

    // Divider and CORDIC operand selection
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_neg   = 1'b0;
        cor_start = 1'b0;
        cor_angle = r_head;
        unique case (i_cmd.op)
            ddo_pkg::OP_DIV_D: begin
                div_start = 1'b1;
                div_num   = {14'd0, sum_mag, 16'd0};
                div_den   = {15'd0, tpm_eff, 1'b0};
                div_neg   = r_sum[33];
            end
            ddo_pkg::OP_DIV_M: begin
                div_start = 1'b1;
                div_num   = {14'd0, diff_mag, 16'd0};
                div_den   = {16'd0, tpm_eff};
                div_neg   = r_diff[33];
            end
            ddo_pkg::OP_DIV_T: begin
                div_start = 1'b1;
                div_num   = {16'd0, dm_mag, 16'd0};
                div_den   = {8'd0, tw_eff};
                div_neg   = r_dm[31];
            end
            ddo_pkg::OP_DIV_LIN: begin
                div_start = 1'b1;
                div_num   = r_prod;
                div_den   = {8'd0, r_el};
                div_neg   = r_d[31];
            end
            ddo_pkg::OP_DIV_ANG: begin
                div_start = 1'b1;
                div_num   = r_prod;
                div_den   = {8'd0, r_el};
                div_neg   = r_thneg;
            end
            ddo_pkg::OP_COR_H: begin
                cor_start = 1'b1;
            end
            ddo_pkg::OP_COR_Q: begin
                cor_start = 1'b1;
                cor_angle = {1'b0, r_head[31:1]};
            end
            default: begin
            end
        endcase
    end

    ddo_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_busy  (cor_busy),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    // Configuration and pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm    <= ddo_pkg::TPM_RESET;
            r_tw     <= ddo_pkg::TW_RESET;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_head   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == ddo_pkg::CFG_TICKS_PER_METER) begin
                    r_tpm <= i_cfg_data[15:0];
                end else if (i_cfg_idx == ddo_pkg::CFG_TRACK_WIDTH) begin
                    r_tw <= i_cfg_data;
                end
            end
            if (i_cmd.op == ddo_pkg::OP_UPDATE) begin
                r_pos_x  <= r_pos_x + r_px[61:30];
                r_pos_y  <= r_pos_y + r_py[61:30];
                r_head   <= r_head + r_dbam;
                r_prev_l <= r_lc;
                r_prev_r <= r_rc;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_neg <= div_neg;
        end
        unique case (i_cmd.op)
            ddo_pkg::OP_LOAD: begin
                r_lc   <= i_left_count;
                r_rc   <= i_right_count;
                r_el   <= i_elapsed_us;
                r_sum  <= (34'(i_left_count) - 34'(r_prev_l))
                        + (34'(i_right_count) - 34'(r_prev_r));
                r_diff <= (34'(i_right_count) - 34'(r_prev_r))
                        - (34'(i_left_count) - 34'(r_prev_l));
            end
            ddo_pkg::OP_CAP_D: begin
                if (div_done) begin
                    r_d <= $signed(sat_q);
                end
            end
            ddo_pkg::OP_CAP_M: begin
                if (div_done) begin
                    r_dm <= $signed(sat_q);
                end
            end
            ddo_pkg::OP_CAP_T: begin
                if (div_done) begin
                    r_thm   <= div_quot[47:0];
                    r_th48  <= r_neg ? 48'(-div_quot[47:0]) : div_quot[47:0];
                    r_thneg <= r_neg;
                end
            end
            ddo_pkg::OP_BAM_LO: begin
                r_bam_lo <= bam_p[47:0];
            end
            ddo_pkg::OP_BAM_HI: begin
                r_dbam <= bam_sum[47:16];
            end
            ddo_pkg::OP_CAP_H: begin
                if (cor_done) begin
                    r_cos <= cor_cos;
                    r_sin <= cor_sin;
                end
            end
            ddo_pkg::OP_MUL_LO: begin
                // Low 17 bits of cos and sin as unsigned partial products.
                r_px <= 64'(r_d * $signed({1'b0, r_cos[16:0]}));
                r_py <= 64'(r_d * $signed({1'b0, r_sin[16:0]}));
            end
            ddo_pkg::OP_MUL_HI: begin
                r_px <= r_px + (64'(r_d * $signed(r_cos[CW-1:17])) <<< 17);
                r_py <= r_py + (64'(r_d * $signed(r_sin[CW-1:17])) <<< 17);
            end
            ddo_pkg::OP_CAP_Q: begin
                if (cor_done) begin
                    r_qz <= ddo_pkg::to_q15(cor_sin);
                    r_qw <= ddo_pkg::to_q15(cor_cos);
                end
            end
            ddo_pkg::OP_MUL_LIN: begin
                r_prod <= 64'(lin_p);
            end
            ddo_pkg::OP_CAP_LIN: begin
                if (div_done) begin
                    r_lin <= (r_el == 24'd0) ? 32'd0 : sat_q;
                end
            end
            ddo_pkg::OP_MUL_ANG: begin
                r_prod <= ang_p;
            end
            ddo_pkg::OP_CAP_ANG: begin
                if (div_done) begin
                    r_ang <= (r_el == 24'd0) ? 32'd0 : sat_q;
                end
            end
            ddo_pkg::OP_OUT: begin
                r_o_x    <= r_pos_x;
                r_o_y    <= r_pos_y;
                r_o_head <= r_head;
                r_o_qz   <= r_qz;
                r_o_qw   <= r_qw;
                r_o_lin  <= r_lin;
                r_o_ang  <= r_ang;
            end
            default: begin
            end
        endcase
    end

    assign o_status.div_busy = div_busy;
    assign o_status.div_done = div_done;
    assign o_status.cor_busy = cor_busy;
    assign o_status.cor_done = cor_done;

    assign o_pos_x            = $signed(r_o_x);
    assign o_pos_y            = $signed(r_o_y);
    assign o_heading          = r_o_head;
    assign o_quat_z           = $signed(r_o_qz);
    assign o_quat_w           = $signed(r_o_qw);
    assign o_linear_velocity  = $signed(r_o_lin);
    assign o_angular_velocity = $signed(r_o_ang);

endmodule

`default_nettype wire

// ----- hdl/ddo_ctrl.sv -----
`default_nettype none

// Sequencer that walks one update through the datapath.
module ddo_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire ddo_pkg::t_status i_status,
    output ddo_pkg::t_cmd         o_cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DIV_D   = 5'd1;
    localparam logic [4:0] S_CAP_D   = 5'd2;
    localparam logic [4:0] S_DIV_M   = 5'd3;
    localparam logic [4:0] S_CAP_M   = 5'd4;
    localparam logic [4:0] S_DIV_T   = 5'd5;
    localparam logic [4:0] S_CAP_T   = 5'd6;
    localparam logic [4:0] S_BAM_LO  = 5'd7;
    localparam logic [4:0] S_BAM_HI  = 5'd8;
    localparam logic [4:0] S_COR_H   = 5'd9;
    localparam logic [4:0] S_CAP_H   = 5'd10;
    localparam logic [4:0] S_MUL_LO  = 5'd11;
    localparam logic [4:0] S_MUL_HI  = 5'd12;
    localparam logic [4:0] S_UPDATE  = 5'd13;
    localparam logic [4:0] S_COR_Q   = 5'd14;
    localparam logic [4:0] S_CAP_Q   = 5'd15;
    localparam logic [4:0] S_MUL_LIN = 5'd16;
    localparam logic [4:0] S_DIV_LIN = 5'd17;
    localparam logic [4:0] S_CAP_LIN = 5'd18;
    localparam logic [4:0] S_MUL_ANG = 5'd19;
    localparam logic [4:0] S_DIV_ANG = 5'd20;
    localparam logic [4:0] S_CAP_ANG = 5'd21;
    localparam logic [4:0] S_OUT     = 5'd22;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = ddo_pkg::OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = ddo_pkg::OP_LOAD;
                    n_state  = S_DIV_D;
                end
            end
            S_DIV_D: begin
                o_cmd.op = ddo_pkg::OP_DIV_D;
                n_state  = S_CAP_D;
            end
            S_CAP_D: begin
                o_cmd.op = ddo_pkg::OP_CAP_D;
                if (i_status.div_done) begin
                    n_state = S_DIV_M;
                end
            end
            S_DIV_M: begin
                o_cmd.op = ddo_pkg::OP_DIV_M;
                n_state  = S_CAP_M;
            end
            S_CAP_M: begin
                o_cmd.op = ddo_pkg::OP_CAP_M;
                if (i_status.div_done) begin
                    n_state = S_DIV_T;
                end
            end
            S_DIV_T: begin
                o_cmd.op = ddo_pkg::OP_DIV_T;
                n_state  = S_CAP_T;
            end
            S_CAP_T: begin
                o_cmd.op = ddo_pkg::OP_CAP_T;
                if (i_status.div_done) begin
                    n_state = S_BAM_LO;
                end
            end
            S_BAM_LO: begin
                o_cmd.op = ddo_pkg::OP_BAM_LO;
                n_state  = S_BAM_HI;
            end
            S_BAM_HI: begin
                o_cmd.op = ddo_pkg::OP_BAM_HI;
                n_state  = S_COR_H;
            end
            S_COR_H: begin
                o_cmd.op = ddo_pkg::OP_COR_H;
                n_state  = S_CAP_H;
            end
            S_CAP_H: begin
                o_cmd.op = ddo_pkg::OP_CAP_H;
                if (i_status.cor_done) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.op = ddo_pkg::OP_MUL_LO;
                n_state  = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.op = ddo_pkg::OP_MUL_HI;
                n_state  = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.op = ddo_pkg::OP_UPDATE;
                n_state  = S_COR_Q;
            end
            S_COR_Q: begin
                o_cmd.op = ddo_pkg::OP_COR_Q;
                n_state  = S_CAP_Q;
            end
            S_CAP_Q: begin
                o_cmd.op = ddo_pkg::OP_CAP_Q;
                if (i_status.cor_done) begin
                    n_state = S_MUL_LIN;
                end
            end
            S_MUL_LIN: begin
                o_cmd.op = ddo_pkg::OP_MUL_LIN;
                n_state  = S_DIV_LIN;
            end
            S_DIV_LIN: begin
                o_cmd.op = ddo_pkg::OP_DIV_LIN;
                n_state  = S_CAP_LIN;
            end
            S_CAP_LIN: begin
                o_cmd.op = ddo_pkg::OP_CAP_LIN;
                if (i_status.div_done) begin
                    n_state = S_MUL_ANG;
                end
            end
            S_MUL_ANG: begin
                o_cmd.op = ddo_pkg::OP_MUL_ANG;
                n_state  = S_DIV_ANG;
            end
            S_DIV_ANG: begin
                o_cmd.op = ddo_pkg::OP_DIV_ANG;
                n_state  = S_CAP_ANG;
            end
            S_CAP_ANG: begin
                o_cmd.op = ddo_pkg::OP_CAP_ANG;
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hold the finished result until the previous one has left.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = ddo_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- tb/sv/differential_drive_odometry_tb.sv -----
`timescale 1ns / 100ps

// One expected or observed result: the pose, the heading quaternion and the
// two velocities.
typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] lin_vel;
    logic signed [31:0] ang_vel;
} pose_t;

// Odometry scoreboard: keeps its own copy of the pose, previous counts and
// configuration, predicts one result for every accepted request and checks
// the results in order against those predictions.
class odometry_scoreboard;

    pose_t       pending_poses[$];
    int          error_count;
    logic [15:0] tick_scale;
    logic [23:0] wheel_base;
    logic [31:0] last_left, last_right, track_x, track_y, track_heading;
    longint      arctan_bam[32];

    function new();
        arctan_bam = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                       10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                       83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                       81, 41, 20, 10, 5, 3, 1, 1, 0};
        error_count   = 0;
        tick_scale    = ddo_pkg::TPM_RESET;
        wheel_base    = ddo_pkg::TW_RESET;
        last_left     = '0;
        last_right    = '0;
        track_x       = '0;
        track_y       = '0;
        track_heading = '0;
    endfunction

    function void set_register(logic [ddo_pkg::CFG_IDX_W-1:0] idx, logic [23:0] data);
        if (idx == ddo_pkg::CFG_TICKS_PER_METER) begin
            tick_scale = data[15:0];
        end else begin
            wheel_base = data;
        end
    endfunction

    function longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Cos and sin of a binary angle in Q2.30; angles in the second and
    // third quadrants are rotated by a half turn and negated afterwards.
    function void rotate(logic [31:0] angle, output longint cos_v, output longint sin_v);
        bit     mirrored;
        longint x, y, z, nx;
        mirrored = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
        if (mirrored) angle = angle + 32'h8000_0000;
        z = longint'($signed(angle));
        x = 652032874;
        y = 0;
        for (int i = 0; i < ddo_pkg::CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> (i % 32));
                y  = y + (x >>> (i % 32));
                z  = z - arctan_bam[i % 32];
            end else begin
                nx = x + (y >>> (i % 32));
                y  = y - (x >>> (i % 32));
                z  = z + arctan_bam[i % 32];
            end
            x = nx;
        end
        cos_v = mirrored ? -x : x;
        sin_v = mirrored ? -y : y;
    endfunction

    function logic [15:0] q15(longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function void note_request(logic [31:0] left, logic [31:0] right, logic [23:0] elapsed);
        longint    tpm, tw, dl, dr, d, dm, th, thc, c, s;
        bit [63:0] bam_product;
        pose_t     p;
        tpm = (tick_scale == 0) ? 1 : longint'(tick_scale);
        tw  = (wheel_base == 0) ? 1 : longint'(wheel_base);
        dl  = longint'($signed(left)) - longint'($signed(last_left));
        dr  = longint'($signed(right)) - longint'($signed(last_right));
        d   = clip32(((dl + dr) * 65536) / (2 * tpm));
        dm  = clip32(((dr - dl) * 65536) / tpm);
        th  = (dm * 65536) / tw;
        bam_product = th * 64'd683565276;

        // The position moves along the heading held before this update.
        rotate(track_heading, c, s);
        track_x       = track_x + 32'((d * c) >>> 30);
        track_y       = track_y + 32'((d * s) >>> 30);
        track_heading = track_heading + bam_product[47:16];
        last_left     = left;
        last_right    = right;

        p.lin_vel = '0;
        p.ang_vel = '0;
        if (elapsed != 0) begin
            thc = th;
            if (thc > (64'sd1 <<< 43)) thc = 64'sd1 <<< 43;
            if (thc < -(64'sd1 <<< 43)) thc = -(64'sd1 <<< 43);
            p.lin_vel = 32'(clip32((d * 1000000) / longint'(elapsed)));
            p.ang_vel = 32'(clip32((thc * 1000000) / longint'(elapsed)));
        end
        rotate(track_heading >> 1, c, s);
        p.pos_x   = track_x;
        p.pos_y   = track_y;
        p.heading = track_heading;
        p.quat_z  = q15(s);
        p.quat_w  = q15(c);
        pending_poses.push_back(p);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $time);
        error_count++;
    endtask

    task check_result(pose_t got);
        pose_t want;
        if (pending_poses.size() == 0) begin
            report("unexpected result", got.heading, '0);
            return;
        end
        want = pending_poses.pop_front();
        if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
        if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
        if (got.heading !== want.heading) report("heading", got.heading, want.heading);
        if (got.quat_z !== want.quat_z) report("quat_z", 32'(got.quat_z), 32'(want.quat_z));
        if (got.quat_w !== want.quat_w) report("quat_w", 32'(got.quat_w), 32'(want.quat_w));
        if (got.lin_vel !== want.lin_vel) report("linear_velocity", got.lin_vel, want.lin_vel);
        if (got.ang_vel !== want.ang_vel) report("angular_velocity", got.ang_vel, want.ang_vel);
    endtask

endclass

module differential_drive_odometry_tb;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [ddo_pkg::CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [ddo_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    logic signed [31:0]               i_left_count = '0;
    logic signed [31:0]               i_right_count = '0;
    logic [23:0]                      i_elapsed_us = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic signed [31:0]               o_pos_x, o_pos_y;
    logic [31:0]                      o_heading;
    logic signed [15:0]               o_quat_z, o_quat_w;
    logic signed [31:0]               o_linear_velocity, o_angular_velocity;

    odometry_scoreboard odo_board = new();

    // Idle percentages for the sender and the receiver in the current phase.
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          quiet_cycles = 0;
    logic [31:0] drive_left = '0, drive_right = '0;

    differential_drive_odometry dut (.*);

    always #5 i_clk = ~i_clk;

    // The receiver drops ready at random in the proportion of the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Both handshakes are sampled at the edge, before any driven update lands,
    // so the predictor sees exactly the request that the block took.
    always @(posedge i_clk) begin
        pose_t seen;
        if (i_in_valid && o_in_ready) begin
            odo_board.note_request(i_left_count, i_right_count, i_elapsed_us);
        end
        if (o_out_valid && i_out_ready) begin
            seen.pos_x   = o_pos_x;
            seen.pos_y   = o_pos_y;
            seen.heading = o_heading;
            seen.quat_z  = o_quat_z;
            seen.quat_w  = o_quat_w;
            seen.lin_vel = o_linear_velocity;
            seen.ang_vel = o_angular_velocity;
            odo_board.check_result(seen);
        end
    end

    // Watchdog: a long stretch with neither a request nor a result taken
    // means the block has hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("[differential_drive_odometry] ERROR");
            $finish;
        end
    end

    // Sends one request and returns at the edge where it is accepted. Valid
    // stays high into the next request unless the sender idles first.
    task send_counts(logic [31:0] left, logic [31:0] right, logic [23:0] elapsed);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_left_count  <= left;
        i_right_count <= right;
        i_elapsed_us  <= elapsed;
        drive_left    = left;
        drive_right   = right;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Registers are only written once every result has come back.
    task write_register(logic [ddo_pkg::CFG_IDX_W-1:0] idx, logic [23:0] data);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (odo_board.pending_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        odo_board.set_register(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly plausible motion: small count changes from the last request and
    // a realistic update period. The rest are arbitrary jumps and times.
    task send_random_motion();
        logic [31:0] left, right;
        logic [23:0] elapsed;
        if ($urandom_range(99) < 85) begin
            left    = drive_left + 32'($signed($urandom_range(4000)) - 2000);
            right   = drive_right + 32'($signed($urandom_range(4000)) - 2000);
            elapsed = 24'($urandom_range(200000));
        end else begin
            left    = $urandom;
            right   = ($urandom_range(1)) ? $urandom : left;
            elapsed = 24'($urandom);
        end
        send_counts(left, right, elapsed);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset configuration. The first result has a
        // zero heading, so quat_w must saturate at its top value.
        send_counts(32'd0, 32'd0, 24'd0);
        send_counts(32'd400, 32'd400, 24'd100000);
        send_counts(32'd400, 32'd800, 24'd100000);
        send_counts(32'd1200, 32'd1000, 24'd0);
        send_counts(32'd900, 32'd300, 24'hFF_FFFF);
        send_counts(32'd900, 32'd300, 24'd1);
        send_counts(32'd50000, 32'd50000, 24'd1);
        send_counts(32'h7FFF_FFFF, 32'h8000_0000, 24'd1);
        send_counts(32'h8000_0000, 32'h7FFF_FFFF, 24'd1000);
        send_counts(32'h8000_0000, 32'h8000_0000, 24'd50000);
        send_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd1);
        send_counts(32'hFFFF_FFFF, 32'h0000_0001, 24'h80_0000);
        send_counts(32'd0, 32'd0, 24'h55_AAAA);
        send_counts(32'd20000, 32'd0, 24'hAA_5555);
        send_counts(32'd20000, 32'd60000, 24'd100000);

        // Phase one: no idling, smallest scales so the position wraps quickly
        // and the heading change is huge.
        write_register(ddo_pkg::CFG_TICKS_PER_METER, 24'd1);
        write_register(ddo_pkg::CFG_TRACK_WIDTH, 24'd1);
        repeat (170) send_random_motion();

        // Phase two: the sender idles often, largest scales.
        sender_idle_pct = 73;
        write_register(ddo_pkg::CFG_TICKS_PER_METER, 24'hFFFF);
        write_register(ddo_pkg::CFG_TRACK_WIDTH, 24'hFF_FFFF);
        repeat (170) send_random_motion();

        // Phase three: the receiver stalls often, back at the usual robot setup.
        sender_idle_pct = 0;
        receiver_stall_pct = 73;
        write_register(ddo_pkg::CFG_TICKS_PER_METER, 24'd400);
        write_register(ddo_pkg::CFG_TRACK_WIDTH, 24'd57581);
        repeat (170) send_random_motion();

        // Phase four: light idling on both sides with random scales.
        sender_idle_pct = 11;
        receiver_stall_pct = 11;
        write_register(ddo_pkg::CFG_TICKS_PER_METER, 24'($urandom_range(65535, 1)));
        write_register(ddo_pkg::CFG_TRACK_WIDTH, 24'($urandom_range(16777215, 1)));
        repeat (170) send_random_motion();

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (odo_board.pending_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (odo_board.error_count == 0) begin
            $display("[differential_drive_odometry] OK");
        end else begin
            $display("[differential_drive_odometry] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ddo_pkg.sv
hdl/ddo_divider.sv
hdl/ddo_cordic.sv
hdl/ddo_datapath.sv
hdl/ddo_ctrl.sv
hdl/differential_drive_odometry.sv
tb/sv/differential_drive_odometry_tb.sv
